FILE: rtl/rsrd_pkg.sv
// Package for the range scan reply decoder: payload types, codes and constants.
package rsrd_pkg;

  localparam int BLOCK_DATA_BYTES = 64;
  localparam int STEP_LIMIT       = 1080;

  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_BIAS  = 8'h30;

  localparam logic [7:0] POS_CMD0       = 8'd0;
  localparam logic [7:0] POS_CMD1       = 8'd1;
  localparam logic [7:0] POS_FIRST_MSD  = 8'd2;
  localparam logic [7:0] POS_FIRST_LSD  = 8'd5;
  localparam logic [7:0] POS_LAST_MSD   = 8'd6;
  localparam logic [7:0] POS_LAST_LSD   = 8'd9;
  localparam logic [7:0] POS_DATA_MIN   = 8'd10;
  localparam logic [7:0] POS_MAX        = 8'd255;

  localparam logic [7:0] DATA_OFFSET_RESET = 8'd47;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_COMMAND = 2'd1,
    ERR_DIGIT   = 2'd2
  } err_code_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [13:0] step_index;
    logic [17:0] distance;
    logic        last_reading;
    logic [1:0]  error_code;
  } out_item_t;

endpackage

FILE: rtl/rsrd_parser.sv
// Byte-wise reply parser: header check, step fields, block skipping and group folding.
module rsrd_parser
  import rsrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  in_item_t   item,
  input  logic [7:0] data_offset,
  output logic       res_valid,
  output out_item_t  res
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [7:0]  pos_r, pos_nxt, pos_eff;
  logic        three_r, three_nxt;
  logic [13:0] first_r, first_nxt;
  logic [13:0] last_r, last_nxt;
  logic [6:0]  bbc_r, bbc_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [13:0] cur_r, cur_nxt;

  logic [7:0]  b;
  logic [5:0]  sixbit;
  logic [3:0]  digit;
  logic        is_digit;
  logic [17:0] acc_shift;
  logic [1:0]  cnt_inc;
  logic [1:0]  need;
  logic        group_done;
  logic        is_last;
  logic [6:0]  bbc_inc;
  logic        block_done;
  logic        take_data;
  logic [13:0] first_acc;
  logic [13:0] last_acc;
  logic [13:0] last_sat;

  assign b         = item.rx_byte;
  assign sixbit    = b[5:0] - CHAR_BIAS[5:0];
  assign digit     = sixbit[3:0];
  assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);

  assign phase_eff = item.frame_start ? PH_HEADER : phase_r;
  assign pos_eff   = item.frame_start ? POS_CMD0 : pos_r;

  assign acc_shift  = {acc_r[11:0], sixbit};
  assign cnt_inc    = cnt_r + 2'd1;
  assign need       = three_r ? 2'd3 : 2'd2;
  assign group_done = (cnt_inc >= need);
  assign is_last    = (cur_r == last_r);
  assign bbc_inc    = bbc_r + 7'd1;
  assign block_done = (bbc_inc >= 7'(BLOCK_DATA_BYTES));

  // Decimal fold: v * 10 + d, kept to 14 bits.
  assign first_acc = ((pos_eff == POS_FIRST_MSD) ? 14'd0 : first_r) * 14'd10 + 14'(digit);
  assign last_acc  = ((pos_eff == POS_LAST_MSD) ? 14'd0 : last_r) * 14'd10 + 14'(digit);
  assign last_sat  = (last_acc >= 14'(STEP_LIMIT)) ? 14'(STEP_LIMIT - 1) : last_acc;

  assign take_data = (phase_eff == PH_DATA) ||
                     ((phase_eff == PH_HEADER) && (pos_eff >= POS_DATA_MIN) &&
                      (pos_eff >= data_offset));

  always_comb begin
    phase_nxt = phase_eff;
    pos_nxt   = pos_eff;
    three_nxt = three_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    bbc_nxt   = bbc_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    res_valid = 1'b0;
    res       = '{step_index: 14'd0, distance: 18'd0, last_reading: 1'b0,
                  error_code: ERR_NONE};

    if (phase_eff == PH_HEADER && pos_eff != POS_MAX) begin
      pos_nxt = pos_eff + 8'd1;
    end

    if (phase_eff == PH_SKIP) begin
      // drop checksum and line feed
      if (bbc_r == 7'd0) begin
        bbc_nxt = 7'd1;
      end else begin
        bbc_nxt   = 7'd0;
        phase_nxt = PH_DATA;
      end
    end else if (take_data) begin
      phase_nxt = PH_DATA;
      acc_nxt   = acc_shift;
      cnt_nxt   = cnt_inc;
      if (group_done) begin
        res_valid = 1'b1;
        res = '{step_index: cur_r, distance: acc_shift, last_reading: is_last,
                error_code: ERR_NONE};
        acc_nxt = 18'd0;
        cnt_nxt = 2'd0;
        if (is_last) begin
          phase_nxt = PH_IDLE;
        end else begin
          cur_nxt = cur_r + 14'd1;
        end
      end
      if (!(group_done && is_last)) begin
        if (block_done) begin
          bbc_nxt   = 7'd0;
          phase_nxt = PH_SKIP;
        end else begin
          bbc_nxt = bbc_inc;
        end
      end
    end else if (phase_eff == PH_HEADER) begin
      if (pos_eff == POS_CMD0) begin
        if (b != CHAR_M) begin
          phase_nxt = PH_IDLE;
          res_valid = 1'b1;
          res.error_code = ERR_COMMAND;
        end
      end else if (pos_eff == POS_CMD1) begin
        if (b == CHAR_D) begin
          three_nxt = 1'b1;
        end else if (b == CHAR_S) begin
          three_nxt = 1'b0;
        end else begin
          phase_nxt = PH_IDLE;
          res_valid = 1'b1;
          res.error_code = ERR_COMMAND;
        end
      end else if (pos_eff <= POS_LAST_LSD) begin
        if (!is_digit) begin
          phase_nxt = PH_IDLE;
          res_valid = 1'b1;
          res.error_code = ERR_DIGIT;
        end else if (pos_eff <= POS_FIRST_LSD) begin
          first_nxt = first_acc;
        end else begin
          last_nxt = last_acc;
          if (pos_eff == POS_LAST_LSD) begin
            last_nxt = last_sat;
            cur_nxt  = first_r;
            acc_nxt  = 18'd0;
            cnt_nxt  = 2'd0;
            bbc_nxt  = 7'd0;
            if (first_r > last_sat) begin
              phase_nxt = PH_IDLE;
            end
          end
        end
      end
    end

    if (!accept) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= 8'd0;
      three_r <= 1'b0;
      first_r <= 14'd0;
      last_r  <= 14'd0;
      bbc_r   <= 7'd0;
      acc_r   <= 18'd0;
      cnt_r   <= 2'd0;
      cur_r   <= 14'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      three_r <= three_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      bbc_r   <= bbc_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
    end
  end

endmodule

FILE: rtl/range_scan_reply_decoder.sv
// Top level of the range scan reply decoder: config register, parser and output stage.
//
//  port group  | dir | handshake            | payload
//  in_*        | in  | in_valid / in_ready  | in_data  (rx_byte, frame_start)
//  out_*       | out | out_valid / out_ready| out_data (step_index, distance,
//              |     |                      |           last_reading, error_code)
//  cfg_*       | in  | cfg_wr_en            | cfg_wr_data (data_offset)
//
// One byte is taken per cycle while in_ready is high; the reading or error that a byte
// completes is registered in the output register, or in the skid while that stalls.
// rst_n is synchronous: the parser goes idle and data_offset returns to 47.
// A two-entry output stage (output register plus skid) keeps in_ready high while
// one result waits; in_ready drops only while both entries hold results.
module range_scan_reply_decoder
  import rsrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0] data_offset_r;
  logic       in_fire;
  logic       out_fire;
  logic       res_valid;
  out_item_t  res;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       skid_valid_r;
  out_item_t  skid_data_r;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_fire  = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_offset_r <= DATA_OFFSET_RESET;
    end else if (cfg_wr_en) begin
      data_offset_r <= cfg_wr_data;
    end
  end

  rsrd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_fire),
    .item        (in_data),
    .data_offset (data_offset_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      // skid is empty here; park the result in it when the output register stays busy
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= res;
      end
    end else if (out_fire) begin
      out_valid_r  <= skid_valid_r;
      out_data_r   <= skid_data_r;
      skid_valid_r <= 1'b0;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("result lost while output stalled");

  a_skid_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(in_fire))
    else $error("skid filled without an input transfer");

endmodule
